### design/aie_pkg.sv
// ----------------------------------------------------------------------------
// aie_pkg
// Operation codes, result codes, opcode tables and item/result types shared
// by the instruction encoder files.
// ----------------------------------------------------------------------------
package aie_pkg;

    // operation codes
    localparam logic [6:0] FN_CALL  = 7'd0;
    localparam logic [6:0] FN_JMP   = 7'd1;
    localparam logic [6:0] FN_LDS   = 7'd2;
    localparam logic [6:0] FN_STS   = 7'd3;
    localparam logic [6:0] FN_MOV   = 7'd4;
    localparam logic [6:0] FN_LSL   = 7'd6;
    localparam logic [6:0] FN_ROL   = 7'd8;
    localparam logic [6:0] FN_TST   = 7'd12;
    localparam logic [6:0] FN_CLR   = 7'd15;
    localparam logic [6:0] FN_MUL   = 7'd18;
    localparam logic [6:0] FN_INC   = 7'd19;
    localparam logic [6:0] FN_POP   = 7'd28;
    localparam logic [6:0] FN_NOP   = 7'd29;
    localparam logic [6:0] FN_WDR   = 7'd35;
    localparam logic [6:0] FN_BRNE  = 7'd36;
    localparam logic [6:0] FN_BRLT  = 7'd43;
    localparam logic [6:0] FN_LDI   = 7'd44;
    localparam logic [6:0] FN_CPI   = 7'd49;
    localparam logic [6:0] FN_MOVW  = 7'd50;
    localparam logic [6:0] FN_ADIW  = 7'd51;
    localparam logic [6:0] FN_SBIW  = 7'd52;
    localparam logic [6:0] FN_OUT   = 7'd53;
    localparam logic [6:0] FN_IN    = 7'd54;
    localparam logic [6:0] FN_SBI   = 7'd55;
    localparam logic [6:0] FN_SBIS  = 7'd58;
    localparam logic [6:0] FN_SBRC  = 7'd59;
    localparam logic [6:0] FN_SBRS  = 7'd60;
    localparam logic [6:0] FN_LDD   = 7'd61;
    localparam logic [6:0] FN_STD   = 7'd62;
    localparam logic [6:0] FN_RJMP  = 7'd63;
    localparam logic [6:0] FN_RCALL = 7'd64;

    // result codes
    localparam logic [1:0] ERR_OK     = 2'd0;
    localparam logic [1:0] ERR_REG    = 2'd1;
    localparam logic [1:0] ERR_RANGE  = 2'd2;
    localparam logic [1:0] ERR_OFFSET = 2'd3;

    // fixed opcode words
    localparam logic [15:0] OP_CALL  = 16'h940E;
    localparam logic [15:0] OP_JMP   = 16'h940C;
    localparam logic [15:0] OP_LDS   = 16'h9000;
    localparam logic [15:0] OP_STS   = 16'h9200;
    localparam logic [15:0] OP_RJMP  = 16'hC000;
    localparam logic [15:0] OP_RCALL = 16'hD000;
    localparam logic [15:0] OP_MOVW  = 16'h0100;
    localparam logic [15:0] OP_ADIW  = 16'h9600;
    localparam logic [15:0] OP_SBIW  = 16'h9700;
    localparam logic [15:0] OP_OUT   = 16'hB800;
    localparam logic [15:0] OP_IN    = 16'hB000;
    localparam logic [15:0] OP_SBRC  = 16'hFC00;
    localparam logic [15:0] OP_SBRS  = 16'hFE00;
    localparam logic [15:0] OP_LDD   = 16'h8000;
    localparam logic [15:0] OP_STD   = 16'h8200;

    localparam logic [15:0] TWO_REG_BASE [0:14] = '{
        16'h2C00, 16'h0C00, 16'h0C00, 16'h1C00, 16'h1C00, 16'h1800, 16'h0800,
        16'h2000, 16'h2000, 16'h2800, 16'h2400, 16'h2400, 16'h1400, 16'h0400,
        16'h9C00
    };
    localparam logic [15:0] ONE_REG_BASE [0:9] = '{
        16'h9403, 16'h940A, 16'h9400, 16'h9401, 16'h9405, 16'h9406, 16'h9407,
        16'h9402, 16'h920F, 16'h900F
    };
    localparam logic [15:0] FIXED_WORD [0:6] = '{
        16'h0000, 16'h9508, 16'h9518, 16'h9478, 16'h94F8, 16'h9588, 16'h95A8
    };
    localparam logic [15:0] BRANCH_WORD [0:7] = '{
        16'hF401, 16'hF001, 16'hF000, 16'hF400, 16'hF002, 16'hF402, 16'hF404,
        16'hF004
    };
    localparam logic [15:0] IMM_BASE [0:5] = '{
        16'hE000, 16'h5000, 16'h4000, 16'h7000, 16'h6000, 16'h3000
    };
    localparam logic [15:0] IO_BIT_BASE [0:3] = '{
        16'h9A00, 16'h9800, 16'h9900, 16'h9B00
    };

    typedef struct packed {
        logic [6:0]         func;
        logic [4:0]         reg_d;
        logic [4:0]         reg_r;
        logic signed [16:0] number;
        logic [3:0]         bit_index;
        logic               pointer_is_y;
        logic               target_relative;
        logic [15:0]        word_address;
    } t_item;

    typedef struct packed {
        logic [15:0] instr_word;
        logic [15:0] extra_word;
        logic        has_extra;
        logic [1:0]  error_code;
    } t_result;

endpackage

### design/aie_in_if.sv
// ----------------------------------------------------------------------------
// aie_in_if
// Valid/ready channel carrying one parsed instruction word.
// ----------------------------------------------------------------------------
interface aie_in_if;
    logic               valid;
    logic               ready;
    logic [6:0]         func;
    logic [4:0]         reg_d;
    logic [4:0]         reg_r;
    logic signed [16:0] number;
    logic [3:0]         bit_index;
    logic               pointer_is_y;
    logic               target_relative;
    logic [15:0]        word_address;

    modport source (
        output valid, func, reg_d, reg_r, number, bit_index, pointer_is_y,
               target_relative, word_address,
        input  ready
    );
    modport sink (
        input  valid, func, reg_d, reg_r, number, bit_index, pointer_is_y,
               target_relative, word_address,
        output ready
    );
endinterface

### design/aie_out_if.sv
// ----------------------------------------------------------------------------
// aie_out_if
// Valid/ready channel carrying one encoded machine word result.
// ----------------------------------------------------------------------------
interface aie_out_if;
    logic        valid;
    logic        ready;
    logic [15:0] instr_word;
    logic [15:0] extra_word;
    logic        has_extra;
    logic [1:0]  error_code;

    modport source (
        output valid, instr_word, extra_word, has_extra, error_code,
        input  ready
    );
    modport sink (
        input  valid, instr_word, extra_word, has_extra, error_code,
        output ready
    );
endinterface

### design/aie_encode.sv
// ----------------------------------------------------------------------------
// aie_encode
// Combinational encoder: range checks and opcode field packing for one
// registered instruction.
// ----------------------------------------------------------------------------
module aie_encode (
    input  aie_pkg::t_item   i_item,
    output aie_pkg::t_result o_result
);
    import aie_pkg::*;

    logic [6:0]         f;
    logic [4:0]         d;
    logic [4:0]         r;
    logic signed [16:0] n;
    logic [17:0]        off_base;
    logic [17:0]        off;
    logic               off_br_ok;
    logic               off_rj_ok;
    logic               n_word_ok;
    logic               n_6bit_ok;
    logic               n_5bit_ok;
    logic               n_imm_ok;
    logic               b_ok;
    logic [15:0]        w;
    logic [15:0]        x;
    logic               two;
    logic [1:0]         err;

    assign f = i_item.func;
    assign d = i_item.reg_d;
    assign n = i_item.number;

    // branch offset relative to the following word
    assign off_base = i_item.target_relative ? 18'd0 : {2'b00, i_item.word_address};
    assign off      = {n[16], n} - off_base - 18'd1;

    assign off_br_ok = (off[17:6] == '0) || (off[17:6] == '1);
    assign off_rj_ok = (off[17:11] == '0) || (off[17:11] == '1);
    assign n_word_ok = !n[16];
    assign n_6bit_ok = (n[16:6] == '0);
    assign n_5bit_ok = (n[16:5] == '0);
    assign n_imm_ok  = (n >= -17'sd128) && (n <= 17'sd255);
    assign b_ok      = !i_item.bit_index[3];

    always_comb begin
        w   = '0;
        x   = '0;
        two = 1'b0;
        err = ERR_OK;
        r   = i_item.reg_r;
        unique case (f) inside
            [FN_CALL:FN_STS]: begin
                if (!n_word_ok) begin
                    err = ERR_RANGE;
                end else begin
                    if (f == FN_CALL)     w = OP_CALL;
                    else if (f == FN_JMP) w = OP_JMP;
                    else if (f == FN_LDS) w = OP_LDS | {7'd0, d, 4'd0};
                    else                  w = OP_STS | {7'd0, d, 4'd0};
                    x   = n[15:0];
                    two = 1'b1;
                end
            end
            [FN_MOV:FN_MUL]: begin
                if (f == FN_LSL || f == FN_ROL || f == FN_TST || f == FN_CLR) begin
                    r = d;
                end
                w = TWO_REG_BASE[4'(f - FN_MOV)] | {6'd0, r[4], d, r[3:0]};
            end
            [FN_INC:FN_POP]: begin
                w = ONE_REG_BASE[4'(f - FN_INC)] | {7'd0, d, 4'd0};
            end
            [FN_NOP:FN_WDR]: begin
                w = FIXED_WORD[3'(f - FN_NOP)];
            end
            [FN_BRNE:FN_BRLT]: begin
                if (!off_br_ok) err = ERR_OFFSET;
                else w = BRANCH_WORD[3'(f - FN_BRNE)] | {6'd0, off[6:0], 3'd0};
            end
            FN_RJMP, FN_RCALL: begin
                if (!off_rj_ok) err = ERR_OFFSET;
                else w = ((f == FN_RJMP) ? OP_RJMP : OP_RCALL) | {4'd0, off[11:0]};
            end
            [FN_LDI:FN_CPI]: begin
                if (!d[4]) begin
                    err = ERR_REG;
                end else if (!n_imm_ok) begin
                    err = ERR_RANGE;
                end else begin
                    w = IMM_BASE[3'(f - FN_LDI)] | {4'd0, n[7:4], d[3:0], n[3:0]};
                end
            end
            FN_MOVW: begin
                if (d[0] || r[0]) err = ERR_REG;
                else w = OP_MOVW | {8'd0, d[4:1], r[4:1]};
            end
            FN_ADIW, FN_SBIW: begin
                if (d[4:3] != 2'b11 || d[0]) begin
                    err = ERR_REG;
                end else if (!n_6bit_ok) begin
                    err = ERR_RANGE;
                end else begin
                    w = ((f == FN_ADIW) ? OP_ADIW : OP_SBIW)
                        | {8'd0, n[5:4], d[2:1], n[3:0]};
                end
            end
            FN_OUT, FN_IN: begin
                if (!n_6bit_ok) begin
                    err = ERR_RANGE;
                end else begin
                    w = ((f == FN_OUT) ? OP_OUT : OP_IN) | {5'd0, n[5:4], d, n[3:0]};
                end
            end
            [FN_SBI:FN_SBIS]: begin
                if (!n_5bit_ok || !b_ok) begin
                    err = ERR_RANGE;
                end else begin
                    w = IO_BIT_BASE[2'(f - FN_SBI)]
                        | {8'd0, n[4:0], i_item.bit_index[2:0]};
                end
            end
            FN_SBRC, FN_SBRS: begin
                if (!b_ok) begin
                    err = ERR_RANGE;
                end else begin
                    w = ((f == FN_SBRC) ? OP_SBRC : OP_SBRS)
                        | {7'd0, d, 1'b0, i_item.bit_index[2:0]};
                end
            end
            FN_LDD, FN_STD: begin
                if (!n_6bit_ok) begin
                    err = ERR_RANGE;
                end else begin
                    w = ((f == FN_LDD) ? OP_LDD : OP_STD)
                        | {2'd0, n[5], 1'b0, n[4:3], 1'b0, d,
                           i_item.pointer_is_y, n[2:0]};
                end
            end
            default: begin
                err = ERR_RANGE;
            end
        endcase
        if (err != ERR_OK) begin
            w   = '0;
            x   = '0;
            two = 1'b0;
        end
    end

    assign o_result.instr_word = w;
    assign o_result.extra_word = x;
    assign o_result.has_extra  = two;
    assign o_result.error_code = err;

endmodule

### design/avr_instruction_encoder_unit.sv
// path: an accepted instruction is held in the input register, then its
// encoded result is held in the result register and offered at the output
// throughput: one instruction per cycle, stalls only when both stages are full
// under output backpressure
// reset: synchronous active-low reset clears both stage valid flags, payload
// registers are not reset
// ----------------------------------------------------------------------------
// avr_instruction_encoder_unit
// Two-stage valid/ready pipeline around the combinational AVR instruction
// encoder.
// ----------------------------------------------------------------------------
module avr_instruction_encoder_unit (
    input  logic      i_clk,
    input  logic      i_rst_n,
    aie_in_if.sink    i_in,
    aie_out_if.source o_out
);
    import aie_pkg::*;

    logic    r_s1_vld;
    logic    n_s1_vld;
    t_item   r_item;
    logic    r_s2_vld;
    logic    n_s2_vld;
    t_result r_res;
    t_result w_res;
    logic    s1_adv;
    logic    in_acc;

    assign s1_adv     = !r_s2_vld || o_out.ready;
    assign i_in.ready = !r_s1_vld || s1_adv;
    assign in_acc     = i_in.valid && i_in.ready;

    assign n_s1_vld = in_acc ? 1'b1 : (s1_adv ? 1'b0 : r_s1_vld);
    assign n_s2_vld = s1_adv ? r_s1_vld : r_s2_vld;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
            r_s2_vld <= 1'b0;
        end else begin
            r_s1_vld <= n_s1_vld;
            r_s2_vld <= n_s2_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_item.func            <= i_in.func;
            r_item.reg_d           <= i_in.reg_d;
            r_item.reg_r           <= i_in.reg_r;
            r_item.number          <= i_in.number;
            r_item.bit_index       <= i_in.bit_index;
            r_item.pointer_is_y    <= i_in.pointer_is_y;
            r_item.target_relative <= i_in.target_relative;
            r_item.word_address    <= i_in.word_address;
        end
        if (s1_adv && r_s1_vld) begin
            r_res <= w_res;
        end
    end

    aie_encode u_encode (
        .i_item   (r_item),
        .o_result (w_res)
    );

    assign o_out.valid      = r_s2_vld;
    assign o_out.instr_word = r_res.instr_word;
    assign o_out.extra_word = r_res.extra_word;
    assign o_out.has_extra  = r_res.has_extra;
    assign o_out.error_code = r_res.error_code;

    a_err_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s2_vld && r_res.error_code != ERR_OK) |->
            (r_res.instr_word == '0 && r_res.extra_word == '0 && !r_res.has_extra))
        else $error("error result carries nonzero fields");

    a_extra_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s2_vld && r_res.has_extra) |->
            (r_res.error_code == ERR_OK && r_res.instr_word[15:12] == 4'h9))
        else $error("two-word result with bad opcode or error");

    a_s1_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> r_s1_vld)
        else $error("accepted item not held in input stage");

    a_s2_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_vld && s1_adv) |=> r_s2_vld)
        else $error("encoded item lost between stages");

endmodule
